// File: src/go_back_n_reliable_transport_assert.svh
// Assertion macros for the go-back-N transport checker.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef GO_BACK_N_RELIABLE_TRANSPORT_ASSERT_SVH
`define GO_BACK_N_RELIABLE_TRANSPORT_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define GBNRT_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("go-back-N transport assertion failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define GBNRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("go-back-N transport assertion failed");

`endif

// File: src/gbnrt_pkg.sv
// Shared types and constants for the go-back-N transport block.
// No dependencies.
package gbnrt_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int IDX_W        = $clog2(QUEUE_DEPTH);
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_RESULTS  = 16;
    localparam int RES_W        = $clog2(MAX_RESULTS + 1);
    localparam int BYTES_W      = 17;

    localparam logic [10:0] MAX_PAYLOAD   = 11'd1500;
    localparam logic [15:0] HEADER_BYTES  = 16'd6;
    localparam logic [15:0] RESEND_RESET  = 16'd100;
    localparam logic [15:0] BUDGET_RESET  = 16'(64 * 1024 / 60);

    localparam logic [2:0] OP_ENQUEUE = 3'd0;
    localparam logic [2:0] OP_TICK    = 3'd1;
    localparam logic [2:0] OP_ACK     = 3'd2;
    localparam logic [2:0] OP_NACK    = 3'd3;
    localparam logic [2:0] OP_UPDATE  = 3'd4;

    localparam logic [2:0] KIND_SEND    = 3'd0;
    localparam logic [2:0] KIND_ACK     = 3'd1;
    localparam logic [2:0] KIND_NACK    = 3'd2;
    localparam logic [2:0] KIND_DELIVER = 3'd3;
    localparam logic [2:0] KIND_FULL    = 3'd4;

    localparam logic REG_RESEND_INTERVAL = 1'b0;
    localparam logic REG_BYTE_BUDGET     = 1'b1;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] handle;
        logic [10:0] size;
        logic [31:0] next_send;
    } entry_t;

    typedef struct packed {
        logic        shift;
        logic        enq;
        logic        nack;
        logic [31:0] nack_id;
        logic [CNT_W-1:0] count;
        entry_t      wr;
    } cell_ctl_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] id;
        logic [15:0] handle;
        logic [10:0] size;
        logic        resend;
    } result_t;

endpackage

// File: src/go_back_n_reliable_transport.sv
// Go-back-N reliable transport, sender queue and receiver side, top level.
// Depends on gbnrt_pkg and gbnrt_cell.
//
// The send queue is a row of QUEUE_DEPTH cells with the head in cell 0. Every item is
// accepted only while the block is idle. A successful enqueue, a nack, a stale ack, an
// unknown operation and a received update that yields nothing finish in their accept
// cycle. A full-queue enqueue and a received update with results then pass through
// ST_EMIT, ST_DLV after an ack, and ST_FIN, each waiting on the output. A tick rotates
// the whole row through cell 0, one entry per cycle when the output can take results, and
// holds the input over all QUEUE_DEPTH cells and ST_FIN. An ack pops one entry per cycle
// until the head is one it keeps. One item is worked at a time; results go out through
// a one-entry holding stage and a one-entry output register.
module go_back_n_reliable_transport
    import gbnrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // packet_id[31:0], time_ms[63:32], payload_handle[79:64], data_size[90:80], zero
    input  logic [95:0] s_axis_tdata,
    // operation[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_id[31:0], out_handle[47:32], out_size[58:48], zero
    output logic [63:0] m_axis_tdata,
    // kind[2:0], is_resend[3]
    output logic [3:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_POP  = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;
    localparam logic [2:0] ST_DLV  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [15:0]      interval_reg, budget_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      send_id_reg, send_id_next;
    logic [31:0]      acked_reg, acked_next;
    logic [31:0]      exp_reg, exp_next;
    logic [31:0]      pid_reg, now_reg, due_reg;
    logic [15:0]      handle_reg;
    result_t          emit_reg, emit_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic             act_reg, act_next;
    logic             burst_reg, burst_next;
    logic [RES_W-1:0] sent_reg, sent_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic             pend_valid_reg, pend_valid_next;
    result_t          pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;
    logic             out_last_reg, out_last_next;

    logic       accept, out_free, go, push, fin;
    result_t    push_res;
    cell_ctl_t  ctl;
    entry_t     cells [QUEUE_DEPTH];
    entry_t     fb;
    entry_t     head;
    logic [32:0] due_sum;
    logic [31:0] eff_ns;
    logic [10:0] enq_size;

    assign head     = cells[0];
    assign out_free = !out_valid_reg || m_axis_tready;
    assign go       = !pend_valid_reg || out_free;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign due_sum  = {1'b0, s_axis_tdata[63:32]} + {17'd0, interval_reg};
    assign enq_size = (s_axis_tdata[90:80] > MAX_PAYLOAD) ? MAX_PAYLOAD : s_axis_tdata[90:80];
    assign eff_ns   = burst_reg ? 32'd0 : head.next_send;

    genvar k;
    generate
        for (k = 0; k < QUEUE_DEPTH; k++)
        begin : g_cell
            entry_t nbr;
            if (k == QUEUE_DEPTH - 1)
            begin : g_tail
                assign nbr = fb;
            end
            else
            begin : g_mid
                assign nbr = cells[k+1];
            end
            gbnrt_cell u_cell (
                .clk   (clk),
                .idx   (IDX_W'(k)),
                .ctl   (ctl),
                .nbr   (nbr),
                .entry (cells[k])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        send_id_next = send_id_reg;
        acked_next  = acked_reg;
        exp_next    = exp_reg;
        emit_next   = emit_reg;
        pos_next    = pos_reg;
        act_next    = act_reg;
        burst_next  = burst_reg;
        sent_next   = sent_reg;
        bytes_next  = bytes_reg;
        push        = 1'b0;
        fin         = 1'b0;
        push_res    = '0;
        fb          = head;
        ctl         = '0;
        ctl.count   = count_reg;
        ctl.nack_id = s_axis_tdata[31:0];
        ctl.wr.id        = send_id_reg;
        ctl.wr.handle    = s_axis_tdata[79:64];
        ctl.wr.size      = enq_size;
        ctl.wr.next_send = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_axis_tuser)
                        OP_ENQUEUE:
                        begin
                            if (count_reg >= CNT_W'(QUEUE_DEPTH))
                            begin
                                emit_next = '{KIND_FULL, send_id_reg, 16'd0, 11'd0, 1'b0};
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                ctl.enq = 1'b1;
                                send_id_next = send_id_reg + 32'd1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_TICK:
                        begin
                            pos_next   = '0;
                            act_next   = 1'b1;
                            burst_next = 1'b0;
                            sent_next  = '0;
                            bytes_next = '0;
                            state_next = ST_SCAN;
                        end
                        OP_ACK:
                        begin
                            if (s_axis_tdata[31:0] >= acked_reg)
                            begin
                                acked_next = s_axis_tdata[31:0] + 32'd1;
                                state_next = ST_POP;
                            end
                        end
                        OP_NACK:
                        begin
                            ctl.nack = (s_axis_tdata[31:0] < send_id_reg);
                        end
                        OP_UPDATE:
                        begin
                            if (s_axis_tdata[31:0] == exp_reg)
                            begin
                                emit_next = '{KIND_ACK, exp_reg, 16'd0, 11'd0, 1'b0};
                                exp_next = exp_reg + 32'd1;
                                state_next = ST_EMIT;
                            end
                            else if (s_axis_tdata[31:0] > exp_reg)
                            begin
                                emit_next = '{KIND_NACK, exp_reg, 16'd0, 11'd0, 1'b0};
                                state_next = ST_EMIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (go)
                begin
                    ctl.shift = 1'b1;
                    pos_next = pos_reg + IDX_W'(1);
                    if ({1'b0, pos_reg} < count_reg)
                    begin
                        fb.next_send = eff_ns;
                        if (act_reg && (now_reg >= eff_ns))
                        begin
                            burst_next = burst_reg || (eff_ns != 32'd0);
                            fb.next_send = due_reg;
                            push = 1'b1;
                            push_res = '{KIND_SEND, head.id, head.handle, head.size,
                                         burst_next};
                            sent_next = sent_reg + RES_W'(1);
                            bytes_next = bytes_reg + BYTES_W'(HEADER_BYTES)
                                         + BYTES_W'(head.size);
                            if ((bytes_next >= BYTES_W'(budget_reg))
                                || (sent_next == RES_W'(MAX_RESULTS)))
                            begin
                                act_next = 1'b0;
                            end
                        end
                        else if (act_reg && burst_reg)
                        begin
                            act_next = 1'b0;
                        end
                    end
                    if (pos_reg == IDX_W'(QUEUE_DEPTH - 1))
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_POP:
            begin
                if ((count_reg != '0) && (head.id <= pid_reg))
                begin
                    ctl.shift = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (go)
                begin
                    push = 1'b1;
                    push_res = emit_reg;
                    state_next = (emit_reg.kind == KIND_ACK) ? ST_DLV : ST_FIN;
                end
            end
            ST_DLV:
            begin
                if (go)
                begin
                    push = 1'b1;
                    push_res = '{KIND_DELIVER, emit_reg.id, handle_reg, 11'd0, 1'b0};
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (go)
                begin
                    fin = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hold the newest result until the next one shows whether it is the last
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        if (push)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = push_res;
        end
        else if (fin && pend_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            interval_reg   <= RESEND_RESET;
            budget_reg     <= BUDGET_RESET;
            count_reg      <= '0;
            send_id_reg    <= '0;
            acked_reg      <= '0;
            exp_reg        <= '0;
            pos_reg        <= '0;
            act_reg        <= 1'b0;
            burst_reg      <= 1'b0;
            sent_reg       <= '0;
            bytes_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            send_id_reg    <= send_id_next;
            acked_reg      <= acked_next;
            exp_reg        <= exp_next;
            pos_reg        <= pos_next;
            act_reg        <= act_next;
            burst_reg      <= burst_next;
            sent_reg       <= sent_next;
            bytes_reg      <= bytes_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we && (cfg_index == REG_RESEND_INTERVAL))
            begin
                interval_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_BYTE_BUDGET))
            begin
                budget_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        emit_reg     <= emit_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        if (accept)
        begin
            pid_reg    <= s_axis_tdata[31:0];
            now_reg    <= s_axis_tdata[63:32];
            handle_reg <= s_axis_tdata[79:64];
            // saturate the resend time
            due_reg    <= due_sum[32] ? 32'hFFFF_FFFF : due_sum[31:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reg.size, out_reg.handle, out_reg.id};
    assign m_axis_tuser  = {out_reg.resend, out_reg.kind};
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: src/gbnrt_cell.sv
// One queue slot of the go-back-N transport row.
// Depends on gbnrt_pkg.
module gbnrt_cell
    import gbnrt_pkg::*;
(
    input  logic             clk,
    input  logic [IDX_W-1:0] idx,
    input  cell_ctl_t        ctl,
    input  entry_t           nbr,
    output entry_t           entry
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;

    assign occupied = {1'b0, idx} < ctl.count;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift)
        begin
            entry_next = nbr;
        end
        else if (ctl.enq && ({1'b0, idx} == ctl.count))
        begin
            entry_next = ctl.wr;
        end
        else if (ctl.nack && occupied && (entry_reg.id == ctl.nack_id))
        begin
            // make this entry due at once
            entry_next.next_send = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: src/gbnrt_checker.sv
// Port-level checker for the go-back-N transport, bound to the top level.
// Depends on gbnrt_pkg and go_back_n_reliable_transport_assert.svh.
`include "go_back_n_reliable_transport_assert.svh"

module gbnrt_checker
    import gbnrt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser
);

    `GBNRT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `GBNRT_ASSERT(a_kind_range, m_axis_tvalid, m_axis_tuser[2:0] <= KIND_FULL)
    `GBNRT_ASSERT(a_resend_on_send, m_axis_tvalid && m_axis_tuser[3],
                  m_axis_tuser[2:0] == KIND_SEND)
    `GBNRT_ASSERT(a_size_only_send, m_axis_tvalid && (m_axis_tuser[2:0] != KIND_SEND),
                  m_axis_tdata[58:48] == 11'd0)
    `GBNRT_ASSERT(a_size_max, m_axis_tvalid, m_axis_tdata[58:48] <= MAX_PAYLOAD)

endmodule

bind go_back_n_reliable_transport gbnrt_checker u_gbnrt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
